FILE: hdl/tshr_pkg.sv
package tshr_pkg;

    // Geometry
    localparam int HISTORY_DEPTH = 64;
    localparam int NUM_CHANNELS  = 8;
    localparam int TOTAL_SLOTS   = NUM_CHANNELS * HISTORY_DEPTH;
    localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int CH_W          = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ADDR_W        = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int CHAN_W   = 3;
    localparam int TEMP_W   = 16;
    localparam int TGT_W    = 16;
    localparam int TIME_W   = 48;
    localparam int STEMP_W  = 12;
    localparam int OCNT_W   = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MAXT_W     = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 2'd2;

    localparam logic [15:0]       THROTTLE_RST   = 16'd1000;
    localparam logic [15:0]       WINDOW_RST     = 16'd2000;
    localparam logic [MAXT_W-1:0] MAX_TEMP_RST   = 15'd4000;
    localparam logic [MAXT_W-1:0] STORE_TEMP_MAX = 15'd4095;

    typedef enum logic [KIND_W-1:0] {
        KIND_RECORD = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_UPD,
        ST_RD_DATA,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic [15:0]       throttle_ms;
        logic [15:0]       window_ms;
        logic [MAXT_W-1:0] max_temp;
    } t_cfg;

    typedef struct packed {
        logic [STEMP_W-1:0] temp;
        logic [TGT_W-1:0]   target;
        logic [TIME_W-1:0]  time_ms;
    } t_sample;

    localparam int SAMPLE_W = $bits(t_sample);

endpackage

FILE: hdl/tshr_in_if.sv
interface tshr_in_if;
    import tshr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [CHAN_W-1:0]        channel;
    logic signed [TEMP_W-1:0] temperature;
    logic signed [TGT_W-1:0]  target;
    logic [TIME_W-1:0]        time_ms;

    modport source (
        output valid, kind, channel, temperature, target, time_ms,
        input  ready
    );

    modport sink (
        input  valid, kind, channel, temperature, target, time_ms,
        output ready
    );
endinterface

FILE: hdl/tshr_out_if.sv
interface tshr_out_if;
    import tshr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    accepted;
    logic [OCNT_W-1:0]       sample_count;
    logic                    sample_valid;
    logic [STEMP_W-1:0]      out_temperature;
    logic signed [TGT_W-1:0] out_target;
    logic [TIME_W-1:0]       out_time_ms;
    logic                    last;

    modport source (
        output valid, accepted, sample_count, sample_valid, out_temperature,
               out_target, out_time_ms, last,
        input  ready
    );

    modport sink (
        input  valid, accepted, sample_count, sample_valid, out_temperature,
               out_target, out_time_ms, last,
        output ready
    );
endinterface

FILE: hdl/tshr_sample_ram.sv
module tshr_sample_ram #(
    parameter int DEPTH  = 512,
    parameter int WIDTH  = 76,
    parameter int ADDR_W = 9
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/tshr_ctrl.sv
module tshr_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tshr_pkg::t_cfg           i_cfg,
    tshr_in_if.sink                  i_in,
    tshr_out_if.source               o_out,
    output logic                     o_ram_we,
    output logic [tshr_pkg::ADDR_W-1:0]   o_ram_waddr,
    output tshr_pkg::t_sample        o_ram_wdata,
    output logic                     o_ram_re,
    output logic [tshr_pkg::ADDR_W-1:0]   o_ram_raddr,
    input  tshr_pkg::t_sample        i_ram_rdata
);
    import tshr_pkg::*;

    t_state r_state, n_state;

    // Latched request
    t_kind                    r_kind;
    logic [CHAN_W-1:0]        r_chan;
    logic signed [TEMP_W-1:0] r_temp;
    logic signed [TGT_W-1:0]  r_target;
    logic [TIME_W-1:0]        r_time;

    // Per-channel ring state
    logic [IDX_W-1:0]  r_head      [NUM_CHANNELS];
    logic [CNT_W-1:0]  r_fill      [NUM_CHANNELS];
    logic [TIME_W-1:0] r_last_time [NUM_CHANNELS];

    // Walk and result state
    logic [IDX_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  r_left;
    logic              r_acc;
    logic [CNT_W-1:0]  r_count;
    t_sample           r_pend;
    logic              r_pend_valid;

    // Output register
    logic               r_out_valid;
    logic               r_out_acc;
    logic [OCNT_W-1:0]  r_out_count;
    logic               r_out_svalid;
    t_sample            r_out_sample;
    logic               r_out_last;

    logic               ch_ok;
    logic [CH_W-1:0]    ch;
    logic [IDX_W-1:0]   cur_head;
    logic [CNT_W-1:0]   cur_fill;
    logic [TIME_W-1:0]  cur_last;
    logic [IDX_W-1:0]   head_next;
    logic [CNT_W-1:0]   fill_next;
    logic [IDX_W-1:0]   newest_idx;
    logic [IDX_W-1:0]   oldest_idx;
    logic [IDX_W-1:0]   ptr_next;
    logic [IDX_W-1:0]   sel_idx;
    logic               temp_ok;
    logic               throttled;
    logic               rec_ok;
    logic               upd_ok;
    logic               match;
    logic               out_free;
    logic               advance;
    logic               emit_pend;
    logic               emit_final;

    // Decode the latched channel
    assign ch_ok    = int'(r_chan) < NUM_CHANNELS;
    assign ch       = CH_W'(r_chan);
    assign cur_head = r_head[ch];
    assign cur_fill = r_fill[ch];
    assign cur_last = r_last_time[ch];

    // Ring index arithmetic
    assign head_next  = (int'(cur_head) == HISTORY_DEPTH - 1) ? '0 : cur_head + 1'b1;
    assign fill_next  = (int'(cur_fill) < HISTORY_DEPTH) ? cur_fill + 1'b1 : cur_fill;
    assign newest_idx = (cur_head == '0) ? IDX_W'(HISTORY_DEPTH - 1) : cur_head - 1'b1;
    assign oldest_idx = (int'(cur_fill) < HISTORY_DEPTH) ? '0 : cur_head;
    assign ptr_next   = (int'(r_ptr) == HISTORY_DEPTH - 1) ? '0 : r_ptr + 1'b1;
    assign sel_idx    = (r_kind == KIND_UPDATE) ? newest_idx : oldest_idx;

    // Record admission: positive, under both limits, outside throttle spacing
    assign temp_ok   = !r_temp[TEMP_W-1] && (r_temp != '0)
                       && (r_temp[MAXT_W-1:0] <= i_cfg.max_temp)
                       && (r_temp[MAXT_W-1:0] <= STORE_TEMP_MAX);
    assign throttled = (cur_last != '0)
                       && ({1'b0, r_time} < ({1'b0, cur_last}
                                             + (TIME_W+1)'(i_cfg.throttle_ms)));
    assign rec_ok    = temp_ok && !throttled;

    // Newest sample still inside the rewrite window
    assign upd_ok = {1'b0, r_time} <= ({1'b0, i_ram_rdata.time_ms}
                                       + (TIME_W+1)'(i_cfg.window_ms));

    // Read walk
    assign match    = i_ram_rdata.time_ms > r_time;
    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = !(match && r_pend_valid && !out_free);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_FINAL;
                if (ch_ok && cur_fill != '0) begin
                    if (r_kind == KIND_UPDATE) begin
                        n_state = ST_UPD;
                    end else if (r_kind == KIND_READ) begin
                        n_state = ST_RD_DATA;
                    end
                end
            end
            ST_UPD: begin
                n_state = ST_FINAL;
            end
            ST_RD_DATA: begin
                if (advance && r_left == CNT_W'(1)) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs: handshake, memory access, emit strobes
    always_comb begin
        i_in.ready  = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = '0;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;
        emit_pend   = 1'b0;
        emit_final  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            ST_EXEC: begin
                if (ch_ok && r_kind == KIND_RECORD && rec_ok) begin
                    o_ram_we           = 1'b1;
                    o_ram_waddr        = ADDR_W'(int'(ch) * HISTORY_DEPTH + int'(cur_head));
                    o_ram_wdata.temp   = r_temp[STEMP_W-1:0];
                    o_ram_wdata.target = r_target;
                    o_ram_wdata.time_ms = r_time;
                end
                if (ch_ok && cur_fill != '0
                    && (r_kind == KIND_UPDATE || r_kind == KIND_READ)) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = ADDR_W'(int'(ch) * HISTORY_DEPTH + int'(sel_idx));
                end
            end
            ST_UPD: begin
                // Write back the newest entry with its new target
                if (upd_ok) begin
                    o_ram_we           = 1'b1;
                    o_ram_waddr        = ADDR_W'(int'(ch) * HISTORY_DEPTH + int'(r_ptr));
                    o_ram_wdata        = i_ram_rdata;
                    o_ram_wdata.target = r_target;
                end
            end
            ST_RD_DATA: begin
                emit_pend = match && r_pend_valid && out_free;
                if (advance && r_left != CNT_W'(1)) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = ADDR_W'(int'(ch) * HISTORY_DEPTH + int'(ptr_next));
                end
            end
            ST_FINAL: begin
                emit_final = out_free;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_head[c]      <= '0;
                r_fill[c]      <= '0;
                r_last_time[c] <= '0;
            end
        end else begin
            r_state <= n_state;

            // Store the record and advance the ring head
            if (r_state == ST_EXEC && ch_ok && r_kind == KIND_RECORD && rec_ok) begin
                r_head[ch]      <= head_next;
                r_fill[ch]      <= fill_next;
                r_last_time[ch] <= r_time;
            end

            // Hold one matching sample so the final one can carry last
            if (r_state == ST_EXEC) begin
                r_pend_valid <= 1'b0;
            end else if (r_state == ST_RD_DATA && advance && match) begin
                r_pend_valid <= 1'b1;
            end

            if (emit_pend || emit_final) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind   <= t_kind'(i_in.kind);
            r_chan   <= i_in.channel;
            r_temp   <= i_in.temperature;
            r_target <= i_in.target;
            r_time   <= i_in.time_ms;
        end

        if (r_state == ST_EXEC) begin
            r_ptr   <= sel_idx;
            r_left  <= cur_fill;
            r_acc   <= ch_ok && r_kind == KIND_RECORD && rec_ok;
            if (!ch_ok) begin
                r_count <= '0;
            end else if (r_kind == KIND_RECORD && rec_ok) begin
                r_count <= fill_next;
            end else begin
                r_count <= cur_fill;
            end
        end

        if (r_state == ST_UPD) begin
            r_acc <= upd_ok;
        end

        // Step the walk
        if (r_state == ST_RD_DATA && advance) begin
            r_ptr  <= ptr_next;
            r_left <= r_left - 1'b1;
            if (match) begin
                r_pend <= i_ram_rdata;
            end
        end

        if (emit_pend) begin
            r_out_acc    <= 1'b0;
            r_out_count  <= OCNT_W'(r_count);
            r_out_svalid <= 1'b1;
            r_out_sample <= r_pend;
            r_out_last   <= 1'b0;
        end else if (emit_final) begin
            r_out_acc    <= r_acc;
            r_out_count  <= OCNT_W'(r_count);
            r_out_svalid <= r_pend_valid;
            r_out_sample <= r_pend_valid ? r_pend : '0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.accepted        = r_out_acc;
    assign o_out.sample_count    = r_out_count;
    assign o_out.sample_valid    = r_out_svalid;
    assign o_out.out_temperature = r_out_sample.temp;
    assign o_out.out_target      = r_out_sample.target;
    assign o_out.out_time_ms     = r_out_sample.time_ms;
    assign o_out.last            = r_out_last;
endmodule

FILE: hdl/throttled_sample_history_ring_unit.sv
// Per-channel history ring of temperature samples held in one single-port-read,
// single-port-write sample memory (channels x ring depth entries, no reset,
// entries are only read once written); ring heads, fill counts and last stored
// times per channel sit in flip-flops and clear on reset. One request is worked
// at a time: a record, an unused kind or an out-of-range channel places its result
// in the output register from the final state that follows execution; an update
// reads the newest entry and writes it back if still inside the rewrite window,
// and a read walks every sample the channel holds, one entry per cycle through
// the single read port unless a matching sample waits on a stalled output.
// Output stalls also hold the final state; a new request is taken once the
// previous one has placed its final result in the output register, even if
// that result has not yet been taken.
module throttled_sample_history_ring_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tshr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tshr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    tshr_in_if.sink                            i_in,
    tshr_out_if.source                         o_out
);
    import tshr_pkg::*;

    t_cfg              r_cfg;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_sample           ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    t_sample           ram_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.throttle_ms <= THROTTLE_RST;
            r_cfg.window_ms   <= WINDOW_RST;
            r_cfg.max_temp    <= MAX_TEMP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THROTTLE: r_cfg.throttle_ms <= i_cfg_wdata;
                CFG_WINDOW:   r_cfg.window_ms   <= i_cfg_wdata;
                CFG_MAX_TEMP: r_cfg.max_temp    <= i_cfg_wdata[MAXT_W-1:0];
                default: ;
            endcase
        end
    end

    tshr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    tshr_sample_ram #(
        .DEPTH  (TOTAL_SLOTS),
        .WIDTH  (SAMPLE_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );
endmodule

FILE: test/tb_throttled_sample_history_ring_unit.sv
`timescale 1ns / 100ps

module tb_throttled_sample_history_ring_unit;
    import tshr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 12;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct {
        t_kind                    kind;
        logic [CHAN_W-1:0]        channel;
        logic signed [TEMP_W-1:0] temperature;
        logic signed [TGT_W-1:0]  target;
        logic [TIME_W-1:0]        time_ms;
    } t_history_request;

    typedef struct {
        logic              accepted;
        logic [OCNT_W-1:0] sample_count;
        logic              sample_valid;
        t_sample           sample;
        logic              last;
    } t_history_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    tshr_in_if  req_if ();
    tshr_out_if rsp_if ();

    throttled_sample_history_ring_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (req_if),
        .o_out       (rsp_if)
    );

    // Mirror of the block: settings, rings and per-channel bookkeeping
    t_cfg              model_cfg;
    t_sample           ring_entry [NUM_CHANNELS][HISTORY_DEPTH];
    int                ring_head [NUM_CHANNELS];
    int                ring_fill [NUM_CHANNELS];
    logic [TIME_W-1:0] newest_stored_ms [NUM_CHANNELS];

    t_history_result   expected_results [$];
    int                fail_count;
    int                quiet_cycles = 0;
    int                hold_off_cycles;
    bit                sender_gaps;
    bit                receiver_stalls;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int stall_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_gap();
        if (!sender_gaps || $urandom_range(0, 1) == 0)
            return 0;
        return stall_length();
    endfunction

    // Append one expectation at the tail of the queue
    function automatic void enqueue_result(t_history_result res);
        expected_results = {expected_results, res};
    endfunction

    function automatic void clear_history();
        model_cfg.throttle_ms = THROTTLE_RST;
        model_cfg.window_ms   = WINDOW_RST;
        model_cfg.max_temp    = MAX_TEMP_RST;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            ring_head[c]        = 0;
            ring_fill[c]        = 0;
            newest_stored_ms[c] = '0;
        end
        expected_results.delete();
    endfunction

    function automatic t_history_request req_of(t_kind kind, int ch, int temp_dd, int tgt,
                                                longint unsigned t);
        t_history_request r;
        r.kind        = kind;
        r.channel     = ch[CHAN_W-1:0];
        r.temperature = temp_dd[TEMP_W-1:0];
        r.target      = tgt[TGT_W-1:0];
        r.time_ms     = t[TIME_W-1:0];
        return r;
    endfunction

    // Work out the results of one accepted request and advance the mirror
    function automatic void predict_results(t_history_request req);
        t_history_result r;
        t_history_result held;
        bit              have_held;
        int              ch;
        int              slot;
        int              n;
        int              oldest;
        int              temp_dd;
        bit              ok;
        longint unsigned t;

        ch             = req.channel;
        t              = req.time_ms;
        r.accepted     = 1'b0;
        r.sample_count = '0;
        r.sample_valid = 1'b0;
        r.sample       = '0;
        r.last         = 1'b1;
        if (ch >= NUM_CHANNELS) begin
            enqueue_result(r);
            return;
        end

        case (req.kind)
            KIND_RECORD: begin
                temp_dd = int'(req.temperature);
                ok = temp_dd > 0 && temp_dd <= int'(model_cfg.max_temp) &&
                     temp_dd <= int'(STORE_TEMP_MAX);
                // throttle only once a nonzero time has been stored
                if (ok && newest_stored_ms[ch] != 0 &&
                    t < newest_stored_ms[ch] + model_cfg.throttle_ms)
                    ok = 1'b0;
                if (ok) begin
                    slot = ring_head[ch];
                    ring_entry[ch][slot].temp    = temp_dd[STEMP_W-1:0];
                    ring_entry[ch][slot].target  = req.target;
                    ring_entry[ch][slot].time_ms = req.time_ms;
                    ring_head[ch] = (slot + 1) % HISTORY_DEPTH;
                    if (ring_fill[ch] < HISTORY_DEPTH)
                        ring_fill[ch]++;
                    newest_stored_ms[ch] = req.time_ms;
                end
                r.accepted     = ok;
                r.sample_count = OCNT_W'(ring_fill[ch]);
                enqueue_result(r);
            end
            KIND_UPDATE: begin
                ok = 1'b0;
                if (ring_fill[ch] != 0) begin
                    slot = (ring_head[ch] + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
                    // a current time before the sample still counts as recent
                    if (t <= ring_entry[ch][slot].time_ms + model_cfg.window_ms) begin
                        ring_entry[ch][slot].target = req.target;
                        ok = 1'b1;
                    end
                end
                r.accepted     = ok;
                r.sample_count = OCNT_W'(ring_fill[ch]);
                enqueue_result(r);
            end
            KIND_READ: begin
                n         = ring_fill[ch];
                oldest    = (n < HISTORY_DEPTH) ? 0 : ring_head[ch];
                have_held = 1'b0;
                r.sample_count = OCNT_W'(n);
                // walk oldest first, hold one back so the final one gets last
                for (int i = 0; i < n; i++) begin
                    slot = (oldest + i) % HISTORY_DEPTH;
                    if (ring_entry[ch][slot].time_ms > t) begin
                        if (have_held)
                            enqueue_result(held);
                        held              = r;
                        held.sample_valid = 1'b1;
                        held.sample       = ring_entry[ch][slot];
                        held.last         = 1'b0;
                        have_held         = 1'b1;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    enqueue_result(held);
                end else begin
                    enqueue_result(r);
                end
            end
            default: begin
                r.sample_count = OCNT_W'(ring_fill[ch]);
                enqueue_result(r);
            end
        endcase
    endfunction

    // Offer one request, hold it until taken, then idle for a random gap
    task automatic send_request(t_history_request req);
        int gap;
        gap = pick_gap();
        req_if.valid       <= 1'b1;
        req_if.kind        <= req.kind;
        req_if.channel     <= req.channel;
        req_if.temperature <= req.temperature;
        req_if.target      <= req.target;
        req_if.time_ms     <= req.time_ms;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        predict_results(req);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering, wait for every expected result, then let the block settle
    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_THROTTLE: model_cfg.throttle_ms = value;
            CFG_WINDOW:   model_cfg.window_ms   = value;
            CFG_MAX_TEMP: model_cfg.max_temp    = value[MAXT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Mostly well-formed traffic on a few busy channels, the rest noise
    function automatic t_history_request random_request();
        t_history_request r;
        int               roll;
        int               ch;
        int               top_temp;
        int               span;
        longint unsigned  base;

        roll = $urandom_range(0, 99);
        ch   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_CHANNELS - 1)
                                           : $urandom_range(0, 2);
        base          = newest_stored_ms[ch];
        r.channel     = ch[CHAN_W-1:0];
        r.temperature = 16'($urandom);
        r.target      = 16'($urandom);
        if (roll < 12) begin
            r.kind = t_kind'($urandom_range(0, 3));
            if (r.kind == KIND_RECORD)
                r.time_ms = 48'(base + $urandom_range(0, 3000));
            else
                r.time_ms = 48'({$urandom, $urandom});
        end else if (roll < 55) begin
            r.kind   = KIND_RECORD;
            top_temp = (int'(model_cfg.max_temp) < int'(STORE_TEMP_MAX)) ?
                       int'(model_cfg.max_temp) : int'(STORE_TEMP_MAX);
            if ($urandom_range(0, 9) == 0)
                r.temperature = 16'($urandom_range(top_temp + 1, top_temp + 100));
            else
                r.temperature = 16'($urandom_range(1, top_temp));
            if ($urandom_range(0, 7) == 0)
                r.time_ms = 48'(base + $urandom_range(0, model_cfg.throttle_ms));
            else
                r.time_ms = 48'(base + model_cfg.throttle_ms + $urandom_range(0, 400));
        end else if (roll < 75) begin
            r.kind = KIND_UPDATE;
            if ($urandom_range(0, 9) == 0 && base > 50)
                r.time_ms = 48'(base - 50);
            else
                r.time_ms = 48'(base + $urandom_range(0, model_cfg.window_ms +
                                                      model_cfg.window_ms / 4 + 20));
        end else begin
            r.kind = KIND_READ;
            span   = 20 * model_cfg.throttle_ms + 2000;
            if ($urandom_range(0, 6) == 0 || base <= span)
                r.time_ms = '0;
            else
                r.time_ms = 48'(base - $urandom_range(0, span));
        end
        return r;
    endfunction

    // Reset values, field extremes and the corner cases of each kind
    task automatic test_directed_defaults();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        send_request(req_of(KIND_READ,   0, 0, 0, 0));
        send_request(req_of(KIND_UPDATE, 1, 0, 5, 0));
        send_request(req_of(KIND_NOP,    2, 0, 0, 0));
        send_request(req_of(KIND_RECORD, 0, 0, 0, 0));
        send_request(req_of(KIND_RECORD, 0, -32768, 0, 0));
        send_request(req_of(KIND_RECORD, 0, -1, 0, 0));
        send_request(req_of(KIND_RECORD, 0, 32767, 0, 0));
        send_request(req_of(KIND_RECORD, 0, 4001, 0, 0));
        // time zero keeps the throttle disarmed for the next record
        send_request(req_of(KIND_RECORD, 0, 4000, -32768, 0));
        send_request(req_of(KIND_RECORD, 0, 1, 32767, 200));
        send_request(req_of(KIND_RECORD, 0, 500, 3, 1199));
        send_request(req_of(KIND_RECORD, 0, 500, 3, 100));
        send_request(req_of(KIND_RECORD, 0, 500, 0, 1200));
        send_request(req_of(KIND_UPDATE, 0, 0, -1, 3200));
        send_request(req_of(KIND_UPDATE, 0, 0, 77, 3201));
        send_request(req_of(KIND_UPDATE, 0, 0, 1234, 0));
        send_request(req_of(KIND_READ,   0, 0, 0, 0));
        send_request(req_of(KIND_READ,   0, 0, 0, 200));
        send_request(req_of(KIND_READ,   0, 0, 0, TIME_MAX));
        send_request(req_of(KIND_RECORD, 3, 3999, 7, TIME_MAX));
        send_request(req_of(KIND_UPDATE, 3, 0, -300, TIME_MAX));
        send_request(req_of(KIND_READ,   3, 0, 0, TIME_MAX - 1));
        send_request(req_of(KIND_NOP,    7, -1, -1, TIME_MAX));
    endtask

    // Each register at its extremes, with the edges of each comparison
    task automatic test_register_extremes();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        write_register(CFG_MAX_TEMP, 16'd32767);
        send_request(req_of(KIND_RECORD, 4, 4096, 0, 10));
        send_request(req_of(KIND_RECORD, 4, 4095, 1, 10));
        send_request(req_of(KIND_RECORD, 4, 32767, 0, 20000));
        write_register(CFG_MAX_TEMP, 16'd1);
        send_request(req_of(KIND_RECORD, 4, 2, 0, 5000));
        send_request(req_of(KIND_RECORD, 4, 1, 2, 5000));
        write_register(CFG_THROTTLE, 16'd0);
        send_request(req_of(KIND_RECORD, 4, 1, 3, 5000));
        send_request(req_of(KIND_RECORD, 4, 1, 4, 4999));
        write_register(CFG_THROTTLE, 16'd65535);
        send_request(req_of(KIND_RECORD, 4, 1, 5, 70534));
        send_request(req_of(KIND_RECORD, 4, 1, 6, 70535));
        write_register(CFG_WINDOW, 16'd0);
        send_request(req_of(KIND_UPDATE, 4, 0, -7, 70535));
        send_request(req_of(KIND_UPDATE, 4, 0, -8, 70536));
        write_register(CFG_WINDOW, 16'd65535);
        send_request(req_of(KIND_UPDATE, 4, 0, -9, 70535 + 65535));
        send_request(req_of(KIND_UPDATE, 4, 0, -10, 70535 + 65536));
        send_request(req_of(KIND_READ,   4, 0, 0, 0));
    endtask

    // Fill one channel past its depth so the oldest entries are overwritten
    task automatic test_ring_wraparound();
        longint unsigned t;
        t_history_request r;
        write_register(CFG_THROTTLE, 16'($urandom_range(0, 300)));
        write_register(CFG_WINDOW, WINDOW_RST);
        write_register(CFG_MAX_TEMP, 16'(MAX_TEMP_RST));
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b1;
        t = 1000;
        // every record clears the throttle so the ring is sure to wrap
        for (int i = 0; i < HISTORY_DEPTH + 4; i++) begin
            r = req_of(KIND_RECORD, 6, $urandom_range(1, 4000), $urandom, 0);
            t = newest_stored_ms[6] + model_cfg.throttle_ms + $urandom_range(1, 200);
            r.time_ms = t[TIME_W-1:0];
            send_request(r);
        end
        send_request(req_of(KIND_READ, 6, 0, 0, 0));
        send_request(req_of(KIND_READ, 6, 0, 0,
                            ring_entry[6][(ring_head[6] + 31) % HISTORY_DEPTH].time_ms));
        send_request(req_of(KIND_UPDATE, 6, 0, -2000, newest_stored_ms[6]));
    endtask

    // Hold the output off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        wait_for_drain();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        hold_off_cycles = HOLD_OFF_CYCLES;
        @(posedge i_clk);
        send_request(req_of(KIND_READ,   6, 0, 0, 0));
        send_request(req_of(KIND_READ,   6, 0, 0, 0));
        send_request(req_of(KIND_RECORD, 6, 100, 9, newest_stored_ms[6] + 60000));
        send_request(req_of(KIND_READ,   6, 0, 0, 0));
        send_request(req_of(KIND_READ,   0, 0, 0, 0));
        send_request(req_of(KIND_NOP,    5, 0, 0, 0));
    endtask

    // Random traffic in phases, each with fresh settings and idling mode
    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++) begin
            write_register(CFG_THROTTLE,
                           ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 1500)));
            write_register(CFG_WINDOW, 16'($urandom_range(0, 3000)));
            write_register(CFG_MAX_TEMP, $urandom_range(0, 1) ?
                           16'($urandom_range(2000, 32767)) : 16'($urandom_range(1, 4095)));
            sender_gaps     = (phase != 0);
            receiver_stalls = (phase != 1);
            for (int i = 0; i < 3; i++)
                send_request(random_request());
        end
        wait_for_drain();
    endtask

    // Drive the output ready: random stalls, plus one long hold-off on request
    initial begin : receiver_ready
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
                rsp_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
                rsp_if.ready <= 1'b0;
                stall_left = stall_length() - 1;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Match each taken result against the oldest expectation
    always @(posedge i_clk) begin : result_checker
        t_history_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("result taken with no expectation pending");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("accepted", 64'(want.accepted), 64'(rsp_if.accepted));
                compare_field("sample_count", 64'(want.sample_count),
                              64'(rsp_if.sample_count));
                compare_field("sample_valid", 64'(want.sample_valid),
                              64'(rsp_if.sample_valid));
                compare_field("out_temperature", 64'(want.sample.temp),
                              64'(rsp_if.out_temperature));
                compare_field("out_target", {48'b0, want.sample.target},
                              {48'b0, rsp_if.out_target});
                compare_field("out_time_ms", 64'(want.sample.time_ms),
                              64'(rsp_if.out_time_ms));
                compare_field("last", 64'(want.last), 64'(rsp_if.last));
            end
        end
    end

    // Abort when nothing moves on either side for too long
    always @(posedge i_clk) begin : watchdog
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_throttled_sample_history_ring_unit NOT OK");
                $finish;
            end
        end
    end

    initial begin : test_sequence
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_wdata        = '0;
        req_if.valid       = 1'b0;
        req_if.kind        = '0;
        req_if.channel     = '0;
        req_if.temperature = '0;
        req_if.target      = '0;
        req_if.time_ms     = '0;
        sender_gaps        = 1'b0;
        receiver_stalls    = 1'b0;
        hold_off_cycles    = 0;
        fail_count         = 0;
        clear_history();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_register_extremes();
        test_ring_wraparound();
        test_output_backpressure();
        test_random_traffic();

        if (fail_count == 0)
            $display("tb_throttled_sample_history_ring_unit OK");
        else
            $display("tb_throttled_sample_history_ring_unit NOT OK");
        $finish;
    end

endmodule

FILE: throttled_sample_history_ring_unit.f
hdl/tshr_pkg.sv
hdl/tshr_in_if.sv
hdl/tshr_out_if.sv
hdl/tshr_sample_ram.sv
hdl/tshr_ctrl.sv
hdl/throttled_sample_history_ring_unit.sv
test/tb_throttled_sample_history_ring_unit.sv
